### hw/rtl/lcc_pkg.sv
// Package for the segmented LED comet chase: widths, codes, state encoding,
// segment colours and marker tables. No dependencies.
package lcc_pkg;

  localparam int FUNC_W   = 2;
  localparam int TIME_W   = 32;
  localparam int LED_W    = 10;
  localparam int LEN_W    = 7;
  localparam int POS_W    = 6;
  localparam int SEG_W    = 4;
  localparam int HEAD_W   = 9;
  localparam int TAIL_W   = 8;
  localparam int MS_W     = 16;
  localparam int CH_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SEG_COUNT = 12;
  localparam int MAX_LEDS  = 768;

  // Division by twelve as a multiply by a scaled reciprocal; exact for n up to 768.
  localparam int PROD_W      = 2 * LED_W;
  localparam int RECIP_12    = 683;
  localparam int RECIP_SHIFT = 13;

  // Iterative divider: quotient bits, one per step.
  localparam int DIV_W     = 8;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int MARK_MAX = 5;
  localparam int MARK_CNT_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LED_COUNT   = 3'd0,
    CFG_TAIL_LENGTH = 3'd1,
    CFG_STEP_MS     = 3'd2,
    CFG_PAUSE_MS    = 3'd3,
    CFG_ALL_SEGS    = 3'd4,
    CFG_SINGLE_SEG  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAUSE,
    ST_INTERVAL,
    ST_SEEK,
    ST_PIXEL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [LED_W-1:0] start;
    logic [LEN_W-1:0] len;
  } seg_geom_t;

  localparam rgb_t SEG_COLOUR [SEG_COUNT] = '{
    '{8'd255, 8'd0,   8'd0  }, '{8'd255, 8'd165, 8'd0  }, '{8'd255, 8'd255, 8'd0  },
    '{8'd128, 8'd255, 8'd0  }, '{8'd0,   8'd128, 8'd0  }, '{8'd0,   8'd255, 8'd128},
    '{8'd0,   8'd0,   8'd255}, '{8'd75,  8'd0,   8'd130}, '{8'd128, 8'd0,   8'd128},
    '{8'd255, 8'd0,   8'd255}, '{8'd255, 8'd192, 8'd203}, '{8'd139, 8'd0,   8'd0  }
  };

  localparam logic [MARK_CNT_W-1:0] MARK_COUNT [SEG_COUNT] = '{
    3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  localparam logic [POS_W-1:0] MARK_POS [SEG_COUNT][MARK_MAX] = '{
    '{6'd3,  6'd9,  6'd15, 6'd21, 6'd27}, '{6'd4,  6'd11, 6'd18, 6'd25, 6'd32},
    '{6'd5,  6'd12, 6'd19, 6'd26, 6'd33}, '{6'd6,  6'd13, 6'd20, 6'd27, 6'd34},
    '{6'd7,  6'd14, 6'd21, 6'd28, 6'd0 }, '{6'd8,  6'd15, 6'd22, 6'd29, 6'd0 },
    '{6'd9,  6'd16, 6'd23, 6'd30, 6'd0 }, '{6'd10, 6'd17, 6'd24, 6'd31, 6'd0 },
    '{6'd2,  6'd8,  6'd14, 6'd20, 6'd0 }, '{6'd3,  6'd9,  6'd15, 6'd21, 6'd0 },
    '{6'd4,  6'd10, 6'd16, 6'd22, 6'd0 }, '{6'd5,  6'd11, 6'd17, 6'd23, 6'd0 }
  };

  // True when position pos of segment seg carries a white marker.
  function automatic logic is_marker(input logic [SEG_W-1:0] seg,
                                     input logic [POS_W-1:0] pos);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < MARK_MAX; i++) begin
      if ((MARK_CNT_W'(i) < MARK_COUNT[seg]) && (MARK_POS[seg][i] == pos)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

### hw/rtl/lcc_cmd_if.sv
// Command channel interface: valid/ready handshake carrying func and now_ms.
// Depends on lcc_pkg for field widths.
interface lcc_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [lcc_pkg::FUNC_W-1:0] func;
  logic [lcc_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, func, now_ms, input ready);
  modport sink   (input valid, func, now_ms, output ready);
endinterface

### hw/rtl/lcc_pixel_if.sv
// Pixel channel interface: valid/ready handshake carrying one LED write.
// Depends on lcc_pkg for field widths.
interface lcc_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [lcc_pkg::LED_W-1:0] led_index;
  logic [lcc_pkg::CH_W-1:0]  red;
  logic [lcc_pkg::CH_W-1:0]  green;
  logic [lcc_pkg::CH_W-1:0]  blue;
  logic                      last_of_frame;

  modport source (output valid, led_index, red, green, blue, last_of_frame, input ready);
  modport sink   (input valid, led_index, red, green, blue, last_of_frame, output ready);
endinterface

### hw/rtl/lcc_div.sv
// Iterative restoring divider: 16-bit dividend by 8-bit divisor, one quotient
// bit per cycle. The caller guarantees the quotient fits in 8 bits. Uses lcc_pkg.
module lcc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [2*lcc_pkg::DIV_W-1:0] dividend,
  input  logic [lcc_pkg::DIV_W-1:0]   divisor,
  output logic                        done,
  output logic [lcc_pkg::DIV_W-1:0]   quotient
);
  import lcc_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     low;
  logic [DIV_W:0]       trial;
  logic                 fits;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial = {rem, low[DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[2*DIV_W-1:DIV_W];
      low      <= dividend[DIV_W-1:0];
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      low      <= {low[DIV_W-2:0], 1'b0};
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

### hw/rtl/lcc_geom.sv
// Segment geometry: start index and length of one of the twelve segments for
// the programmed LED count. Uses lcc_pkg.
module lcc_geom (
  input  logic [lcc_pkg::LED_W-1:0] led_count,
  input  logic [lcc_pkg::SEG_W-1:0] seg,
  output lcc_pkg::seg_geom_t        geom
);
  import lcc_pkg::*;

  logic [LED_W-1:0]  n;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  per;
  logic [LED_W-1:0]  per_x12;
  logic [SEG_W-1:0]  rem;
  logic              extra;
  logic [LED_W-1:0]  base;

  assign n       = (led_count > LED_W'(MAX_LEDS)) ? LED_W'(MAX_LEDS) : led_count;
  // n / 12 through the reciprocal, remainder by multiply back and subtract.
  assign prod    = PROD_W'(n) * PROD_W'(RECIP_12);
  assign per     = prod[RECIP_SHIFT +: LEN_W];
  assign per_x12 = {per, 3'b000} + {1'b0, per, 2'b00};
  assign rem     = SEG_W'(n - per_x12);
  assign extra   = seg < rem;
  assign base    = LED_W'(seg) * LED_W'(per);

  assign geom.len   = per + LEN_W'(extra);
  assign geom.start = base + (extra ? LED_W'(seg) : LED_W'(rem));

endmodule

### hw/rtl/segmented_led_comet_chase_top.sv
// Top level of the segmented LED comet chase: configuration registers, the
// sequencer and the pixel output register. Uses lcc_pkg, lcc_cmd_if,
// lcc_pixel_if, lcc_geom and lcc_div.
//
//   Channel   Role    Carries                                     Handshake
//   cmd       sink    func, now_ms                                valid/ready
//   pixel     source  led_index, red, green, blue, last_of_frame  valid/ready
//   cfg       write   cfg_index, cfg_data                         cfg_write, no wait
//
// Start and stop are handled in the idle state. A tick that shows nothing passes
// through at most the pause and interval states, and in all-segments mode the
// seek state once for each empty segment it looks at. A frame passes through
// the setup states (with the seek state in all-segments mode, once more per
// skipped empty segment), then the pixel and emit states for each dark LED and
// the pixel, divide and emit states for each lit LED; the divide state waits on
// the shared eight-step divider that works out the tail brightness.
// Reset is synchronous and active high; it stops the flow and loads the
// register defaults. A stalled pixel channel simply holds the sequencer in its
// emit state; the command channel is ready only while the sequencer is idle.
module segmented_led_comet_chase_top (
  input  logic                            clk,
  input  logic                            rst,
  lcc_cmd_if.sink                         cmd,
  lcc_pixel_if.source                     pixel,
  input  logic                            cfg_write,
  input  logic [lcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lcc_pkg::*;

  // Configuration registers.
  logic [LED_W-1:0]  led_count;
  logic [TAIL_W-1:0] tail_length;
  logic [MS_W-1:0]   step_interval_ms;
  logic [MS_W-1:0]   pause_ms;
  logic              all_segs;
  logic [SEG_W-1:0]  single_segment;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count        <= LED_W'(240);
      tail_length      <= TAIL_W'(5);
      step_interval_ms <= MS_W'(50);
      pause_ms         <= MS_W'(500);
      all_segs         <= 1'b0;
      single_segment   <= '0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LED_COUNT:   led_count        <= cfg_data[LED_W-1:0];
        CFG_TAIL_LENGTH: tail_length      <= cfg_data[TAIL_W-1:0];
        CFG_STEP_MS:     step_interval_ms <= cfg_data[MS_W-1:0];
        CFG_PAUSE_MS:    pause_ms         <= cfg_data[MS_W-1:0];
        CFG_ALL_SEGS:    all_segs         <= cfg_data[0];
        CFG_SINGLE_SEG:  single_segment   <= cfg_data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow state and its next values.
  state_t            state, state_next;
  logic              running, running_next;
  logic              all_mode, all_mode_next;
  logic [HEAD_W-1:0] head, head_next;
  logic [SEG_W-1:0]  cursor, cursor_next;
  logic              pausing, pausing_next;
  logic [TIME_W-1:0] pause_end, pause_end_next;
  logic [TIME_W-1:0] last_step, last_step_next;

  // Per-request and per-frame working registers.
  logic [TIME_W-1:0] now_r, now_r_next;
  logic [SEG_W-1:0]  seg_r, seg_r_next;
  logic [LED_W-1:0]  start_r, start_r_next;
  logic [LEN_W-1:0]  len_r, len_r_next;
  logic [POS_W-1:0]  idx, idx_next;
  logic              lit, lit_next;

  // Pixel output register.
  logic              out_valid, out_valid_next;
  logic [LED_W-1:0]  out_index, out_index_next;
  rgb_t              out_rgb, out_rgb_next;
  logic              out_last, out_last_next;

  // Geometry of the segment in question: the cursor in all-segments mode,
  // the selected segment otherwise.
  logic [SEG_W-1:0] seg_sel;
  seg_geom_t        geom;

  assign seg_sel = all_mode ? cursor : single_segment;

  lcc_geom u_geom (
    .led_count (led_count),
    .seg       (seg_sel),
    .geom      (geom)
  );

  // The shared divider works out (255 * t) / tail for each lit LED.
  logic                 div_start;
  logic [2*DIV_W-1:0]   div_dividend;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;

  lcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (tail_length),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Tail distance of the current LED from the head, and whether it is lit.
  logic [HEAD_W-1:0] tail_dist;
  logic              lit_now;
  logic [TAIL_W-1:0] dist8;

  assign tail_dist = head - HEAD_W'(idx);
  assign lit_now   = (head >= HEAD_W'(idx)) && (tail_dist < HEAD_W'(tail_length));
  assign dist8     = tail_dist[TAIL_W-1:0];
  assign div_dividend = {dist8, {DIV_W{1'b0}}} - {{DIV_W{1'b0}}, dist8};

  // Colour of the current LED: each channel scaled by (brightness + 1) / 256,
  // where brightness + 1 = 256 - quotient. A lit marker shows white instead.
  rgb_t                base_rgb;
  rgb_t                scaled_rgb;
  rgb_t                pixel_rgb;
  logic [DIV_W:0]      scale;
  logic [2*CH_W:0]     prod_r, prod_g, prod_b;
  logic                white;

  assign base_rgb     = SEG_COLOUR[seg_r];
  assign scale        = (DIV_W+1)'(256) - (DIV_W+1)'(div_quo);
  assign prod_r       = (2*CH_W+1)'(base_rgb.r) * (2*CH_W+1)'(scale);
  assign prod_g       = (2*CH_W+1)'(base_rgb.g) * (2*CH_W+1)'(scale);
  assign prod_b       = (2*CH_W+1)'(base_rgb.b) * (2*CH_W+1)'(scale);
  assign scaled_rgb.r = prod_r[2*CH_W-1:CH_W];
  assign scaled_rgb.g = prod_g[2*CH_W-1:CH_W];
  assign scaled_rgb.b = prod_b[2*CH_W-1:CH_W];
  assign white        = is_marker(seg_r, idx);

  always_comb begin
    if (!lit) begin
      pixel_rgb = '0;
    end else if (white) begin
      pixel_rgb = '1;
    end else begin
      pixel_rgb = scaled_rgb;
    end
  end

  // Frame bookkeeping.
  logic              cmd_accept;
  logic              slot_free;
  logic              last_led;
  logic [LED_W-1:0]  head_sum;
  logic [LED_W-1:0]  run_limit;
  logic              halt;

  assign cmd_accept = cmd.valid && cmd.ready;
  assign slot_free  = !out_valid || pixel.ready;
  assign last_led   = LEN_W'(idx) == (len_r - LEN_W'(1));
  assign head_sum   = LED_W'(head) + LED_W'(1);
  assign run_limit  = LED_W'(len_r) + LED_W'(tail_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    running_next   = running;
    all_mode_next  = all_mode;
    head_next      = head;
    cursor_next    = cursor;
    pausing_next   = pausing;
    pause_end_next = pause_end;
    last_step_next = last_step;
    now_r_next     = now_r;
    seg_r_next     = seg_r;
    start_r_next   = start_r;
    len_r_next     = len_r;
    idx_next       = idx;
    lit_next       = lit;
    out_valid_next = out_valid && !pixel.ready;
    out_index_next = out_index;
    out_rgb_next   = out_rgb;
    out_last_next  = out_last;
    div_start      = 1'b0;
    halt           = 1'b0;

    case (state)
      ST_IDLE: begin
        if (cmd_accept) begin
          now_r_next = cmd.now_ms;
          case (func_t'(cmd.func))
            FUNC_START: begin
              running_next   = 1'b1;
              all_mode_next  = all_segs;
              head_next      = '0;
              cursor_next    = '0;
              pausing_next   = 1'b0;
              last_step_next = cmd.now_ms;
            end
            FUNC_STOP: begin
              halt = 1'b1;
            end
            FUNC_TICK: begin
              if (running) begin
                state_next = ST_PAUSE;
              end
            end
            default: ;
          endcase
        end
      end

      // A pause that has run out restarts the step interval from now.
      ST_PAUSE: begin
        state_next = ST_INTERVAL;
        if (pausing) begin
          if (now_r < pause_end) begin
            state_next = ST_IDLE;
          end else begin
            pausing_next   = 1'b0;
            last_step_next = now_r;
          end
        end
      end

      ST_INTERVAL: begin
        if ((now_r - last_step) < TIME_W'(step_interval_ms)) begin
          state_next = ST_IDLE;
        end else begin
          last_step_next = now_r;
          if (all_mode) begin
            state_next = ST_SEEK;
          end else if ((single_segment >= SEG_W'(SEG_COUNT)) || (geom.len == '0)) begin
            halt       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            seg_r_next   = single_segment;
            start_r_next = geom.start;
            len_r_next   = geom.len;
            idx_next     = '0;
            state_next   = ST_PIXEL;
          end
        end
      end

      // All-segments mode skips empty segments, one per cycle.
      ST_SEEK: begin
        if (geom.len != '0) begin
          seg_r_next   = cursor;
          start_r_next = geom.start;
          len_r_next   = geom.len;
          idx_next     = '0;
          state_next   = ST_PIXEL;
        end else if (cursor == SEG_W'(SEG_COUNT - 1)) begin
          halt       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cursor_next = cursor + 1'b1;
        end
      end

      ST_PIXEL: begin
        lit_next = lit_now;
        if (lit_now) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_index_next = start_r + LED_W'(idx);
          out_rgb_next   = pixel_rgb;
          out_last_next  = last_led;
          if (last_led) begin
            state_next = ST_IDLE;
            head_next  = head_sum[HEAD_W-1:0];
            if (head_sum >= run_limit) begin
              if (!all_mode) begin
                halt = 1'b1;
              end else begin
                head_next = '0;
                if (cursor == SEG_W'(SEG_COUNT - 1)) begin
                  halt = 1'b1;
                end else begin
                  cursor_next    = cursor + 1'b1;
                  pausing_next   = 1'b1;
                  pause_end_next = now_r + TIME_W'(pause_ms);
                end
              end
            end
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_PIXEL;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase

    if (halt) begin
      running_next = 1'b0;
      pausing_next = 1'b0;
      head_next    = '0;
      cursor_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      all_mode  <= 1'b0;
      head      <= '0;
      cursor    <= '0;
      pausing   <= 1'b0;
      pause_end <= '0;
      last_step <= '0;
      out_valid <= 1'b0;
    end else begin
      running   <= running_next;
      all_mode  <= all_mode_next;
      head      <= head_next;
      cursor    <= cursor_next;
      pausing   <= pausing_next;
      pause_end <= pause_end_next;
      last_step <= last_step_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_r_next;
    seg_r     <= seg_r_next;
    start_r   <= start_r_next;
    len_r     <= len_r_next;
    idx       <= idx_next;
    lit       <= lit_next;
    out_index <= out_index_next;
    out_rgb   <= out_rgb_next;
    out_last  <= out_last_next;
  end

  assign cmd.ready           = state == ST_IDLE;
  assign pixel.valid         = out_valid;
  assign pixel.led_index     = out_index;
  assign pixel.red           = out_rgb.r;
  assign pixel.green         = out_rgb.g;
  assign pixel.blue          = out_rgb.b;
  assign pixel.last_of_frame = out_last;

  // The cursor never leaves the range of real segments.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= SEG_W'(SEG_COUNT - 1))
    else $error("segment cursor out of range");

  // A stopped flow never has a pause pending.
  a_pause_needs_run: assert property (@(posedge clk) disable iff (rst)
    !running |-> !pausing)
    else $error("pause pending while stopped");

  // A new pixel is loaded only from the emit state.
  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("pixel loaded outside emit state");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider result with nobody waiting");

endmodule

### verif/segmented_led_comet_chase_top_tb.sv
// Self-checking testbench for segmented_led_comet_chase_top: feeds start, stop and
// tick requests, predicts every LED write of each frame and checks them in order.
// Depends on lcc_pkg, lcc_cmd_if, lcc_pixel_if and the RTL top level.
module segmented_led_comet_chase_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcc_pkg::*;

  localparam int GAP_PCT       = 23;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD     = 600;
  localparam int MAX_REPORTS   = 10;

  // The one function code that the block has no meaning for.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] now_ms;
  } chase_req_t;

  typedef struct packed {
    logic [LED_W-1:0] led_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last_of_frame;
  } led_write_t;

  // Colour of each segment as red, green, blue.
  localparam logic [23:0] HUE [SEG_COUNT] = '{
    24'hFF0000, 24'hFFA500, 24'hFFFF00, 24'h80FF00, 24'h008000, 24'h00FF80,
    24'h0000FF, 24'h4B0082, 24'h800080, 24'hFF00FF, 24'hFFC0CB, 24'h8B0000
  };

  // White marker positions per segment. 99 fills an unused slot: no segment is
  // ever that long, so it can never light.
  localparam int MARKS [SEG_COUNT][5] = '{
    '{3, 9, 15, 21, 27}, '{4, 11, 18, 25, 32}, '{5, 12, 19, 26, 33},
    '{6, 13, 20, 27, 34}, '{7, 14, 21, 28, 99}, '{8, 15, 22, 29, 99},
    '{9, 16, 23, 30, 99}, '{10, 17, 24, 31, 99}, '{2, 8, 14, 20, 99},
    '{3, 9, 15, 21, 99}, '{4, 10, 16, 22, 99}, '{5, 11, 17, 23, 99}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  lcc_cmd_if   cmd_ch ();
  lcc_pixel_if pix_ch ();

  segmented_led_comet_chase_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .pixel     (pix_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the configuration registers, loaded with the reset values.
  logic [LED_W-1:0]  cfg_leds     = 10'd240;
  logic [TAIL_W-1:0] cfg_tail     = 8'd5;
  logic [MS_W-1:0]   cfg_step     = 16'd50;
  logic [MS_W-1:0]   cfg_pause    = 16'd500;
  logic              cfg_all_segs = 1'b0;
  logic [SEG_W-1:0]  cfg_seg      = '0;

  // Our own copy of the sequencer state.
  bit                flow_on       = 1'b0;
  bit                all_segs_mode = 1'b0;
  bit                pausing       = 1'b0;
  int                head          = 0;
  int                cursor        = 0;
  logic [TIME_W-1:0] pause_end     = '0;
  logic [TIME_W-1:0] last_step     = '0;

  chase_req_t request_q [$];
  led_write_t pixel_expect_q [$];

  logic              cmd_taken   = 1'b0;
  bit                steady      = 1'b0;
  bit                hold_armed  = 1'b0;
  bit                pixel_hold  = 1'b0;
  logic [TIME_W-1:0] wall_ms     = '0;
  int                errors      = 0;

  // 2 ns clock, high and low for one nanosecond each.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Every input of the block is known from time zero onwards.
  initial begin
    cmd_ch.valid  = 1'b0;
    cmd_ch.func   = FUNC_TICK;
    cmd_ch.now_ms = '0;
    pix_ch.ready  = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  function automatic void halt_flow();
    flow_on = 1'b0;
    pausing = 1'b0;
    head    = 0;
    cursor  = 0;
  endfunction

  // One channel scaled by the tail brightness b (0..255).
  function automatic logic [CH_W-1:0] dim(input logic [CH_W-1:0] c, input int b);
    return CH_W'((int'(c) * (b + 1)) >> 8);
  endfunction

  // Applies one accepted request to the state copy and queues the LED writes
  // that it causes, in LED order.
  function automatic void predict_frame(input logic [FUNC_W-1:0] f,
                                        input logic [TIME_W-1:0] now);
    int                n, per, rem, seg, first, len, b, m;
    logic [TIME_W-1:0] gap;
    logic [23:0]       hue;
    logic [23:0]       shade [64];
    led_write_t        w;

    if (f == FUNC_START) begin
      flow_on       = 1'b1;
      all_segs_mode = cfg_all_segs;
      head          = 0;
      cursor        = 0;
      pausing       = 1'b0;
      last_step     = now;
      return;
    end
    if (f == FUNC_STOP) begin
      halt_flow();
      return;
    end
    if (f != FUNC_TICK || !flow_on) return;

    // A pause ends on the first tick at or after its end time; that tick then
    // restarts the interval and so normally shows nothing itself.
    if (pausing) begin
      if (now < pause_end) return;
      pausing   = 1'b0;
      last_step = now;
    end
    gap = now - last_step;
    if (gap < cfg_step) return;
    last_step = now;

    n   = (cfg_leds > MAX_LEDS) ? MAX_LEDS : int'(cfg_leds);
    per = n / SEG_COUNT;
    rem = n % SEG_COUNT;

    if (!all_segs_mode) begin
      seg = cfg_seg;
      if (seg >= SEG_COUNT) begin
        halt_flow();
        return;
      end
    end else begin
      // Empty segments are skipped; running off the end stops the flow.
      while (cursor < SEG_COUNT && per == 0 && cursor >= rem) cursor++;
      if (cursor >= SEG_COUNT) begin
        halt_flow();
        return;
      end
      seg = cursor;
    end
    len   = per + ((seg < rem) ? 1 : 0);
    first = seg * per + ((seg < rem) ? seg : rem);
    if (len == 0) begin
      halt_flow();
      return;
    end

    hue = HUE[seg];
    for (int i = 0; i < len; i++) shade[i] = '0;
    for (int t = 0; t < cfg_tail; t++) begin
      if (head >= t && head - t < len) begin
        b = 255 - (255 * t) / int'(cfg_tail);
        shade[head - t] = {dim(hue[23:16], b), dim(hue[15:8], b), dim(hue[7:0], b)};
      end
    end
    for (int k = 0; k < 5; k++) begin
      m = MARKS[seg][k];
      if (m < len && head >= m && head - m < cfg_tail) shade[m] = 24'hFFFFFF;
    end
    for (int i = 0; i < len; i++) begin
      w.led_index     = LED_W'(first + i);
      w.red           = shade[i][23:16];
      w.green         = shade[i][15:8];
      w.blue          = shade[i][7:0];
      w.last_of_frame = (i == len - 1);
      pixel_expect_q.insert(pixel_expect_q.size(), w);
    end

    // Once the whole tail has left the segment the run is over: single mode
    // stops, all mode moves on to the next segment after a pause.
    if (head + 1 >= len + cfg_tail) begin
      if (!all_segs_mode) begin
        halt_flow();
      end else begin
        cursor++;
        head = 0;
        if (cursor >= SEG_COUNT) begin
          halt_flow();
        end else begin
          pausing   = 1'b1;
          pause_end = now + cfg_pause;
        end
      end
    end else begin
      head = (head + 1) & 9'h1FF;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Command side: driver at the falling edge, acceptance at the rising edge
  // ---------------------------------------------------------------------------

  // A request stays on the channel until it is taken; a new one is offered
  // only after that, unless a random gap is drawn.
  always @(negedge clk) begin : request_driver
    chase_req_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (request_q.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT)) begin
        nxt = request_q.pop_front();
        cmd_ch.valid  <= 1'b1;
        cmd_ch.func   <= nxt.func;
        cmd_ch.now_ms <= nxt.now_ms;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cmd_taken <= !rst && cmd_ch.valid && cmd_ch.ready;
    if (!rst && cmd_ch.valid && cmd_ch.ready) predict_frame(cmd_ch.func, cmd_ch.now_ms);
  end

  // ---------------------------------------------------------------------------
  // Pixel side: ready at the falling edge, checking at the rising edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      pix_ch.ready <= 1'b0;
    end else begin
      pix_ch.ready <= !pixel_hold && (steady || $urandom_range(99) >= GAP_PCT);
    end
  end

  function automatic void flag(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : pixel_check
    led_write_t got, want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      got = '{pix_ch.led_index, pix_ch.red, pix_ch.green, pix_ch.blue,
              pix_ch.last_of_frame};
      if (pixel_expect_q.size() == 0) begin
        flag($sformatf("LED write %0d arrived with nothing expected", got.led_index));
      end else begin
        want = pixel_expect_q.pop_front();
        if (got !== want) begin
          flag($sformatf({"LED write differs: expected idx %0d rgb %02x %02x %02x last %0b,",
                          " got idx %0d rgb %02x %02x %02x last %0b"},
                         want.led_index, want.red, want.green, want.blue,
                         want.last_of_frame, got.led_index, got.red, got.green,
                         got.blue, got.last_of_frame));
        end
      end
    end
  end

  // Long back-pressure: once armed, the first frame that appears is held for
  // a long stretch, so the block stalls in its emit state while the command
  // side keeps offering requests that it cannot take.
  initial begin : pixel_backpressure
    wait (hold_armed);
    do @(posedge clk); while (!pix_ch.valid);
    pixel_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    pixel_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void push_req(input logic [FUNC_W-1:0] f,
                                   input logic [TIME_W-1:0] t);
    chase_req_t r;
    r.func   = f;
    r.now_ms = t;
    request_q.insert(request_q.size(), r);
  endfunction

  // Register writes happen only while the block is idle; our copy follows.
  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    case (idx)
      CFG_LED_COUNT:   cfg_leds     = LED_W'(value);
      CFG_TAIL_LENGTH: cfg_tail     = TAIL_W'(value);
      CFG_STEP_MS:     cfg_step     = MS_W'(value);
      CFG_PAUSE_MS:    cfg_pause    = MS_W'(value);
      CFG_ALL_SEGS:    cfg_all_segs = value[0];
      CFG_SINGLE_SEG:  cfg_seg      = SEG_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every request has been taken and every LED write has come
  // back, then lets the sequencer settle back to idle.
  task automatic drain();
    do @(negedge clk);
    while (request_q.size() != 0 || cmd_ch.valid || pixel_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  // One comet run: a start and then ticks spaced so that most of them step the
  // comet. In wide mode the spacing also covers the pause between segments.
  // Noisy runs mix in early ticks, time jumps, stray codes and stop/restart.
  task automatic push_run(input int ticks, input bit wide, input bit noisy);
    int                pick;
    logic [TIME_W-1:0] stride;
    stride = (wide && cfg_pause > cfg_step) ? cfg_pause : cfg_step;
    push_req(FUNC_START, wall_ms);
    repeat (ticks) begin
      pick = noisy ? $urandom_range(99) : 99;
      if (pick < 4) begin
        push_req(FUNC_STOP, $urandom);
        push_req(FUNC_START, wall_ms);
      end else if (pick < 8) begin
        push_req(FUNC_UNUSED, $urandom);
      end else begin
        if (pick < 16) wall_ms += (cfg_step == 0) ? 0 : $urandom_range(cfg_step - 1);
        else if (pick < 21) wall_ms = $urandom;
        else wall_ms += stride + $urandom_range(2);
        push_req(FUNC_TICK, wall_ms);
      end
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset configuration: 20-LED segment 0, tail of five, 50 ms
    // steps. A tick while stopped, a stray code and a stop do nothing; then a
    // run whose step interval straddles the wrap of the millisecond count.
    push_req(FUNC_TICK, 32'd100);
    push_req(FUNC_UNUSED, 32'hFFFF_FFFF);
    push_req(FUNC_STOP, 32'd0);
    push_req(FUNC_START, 32'hFFFF_FFE0);
    push_req(FUNC_TICK, 32'h0000_0011);      // one short of the interval
    for (int i = 0; i < 5; i++) push_req(FUNC_TICK, 32'h12 + 50 * i);
    push_req(FUNC_TICK, 32'h12 + 200 + 49);  // early again
    push_req(FUNC_STOP, 32'h0000_1000);
    push_req(FUNC_TICK, 32'h0000_2000);      // flow is stopped
    push_req(FUNC_START, 32'h8000_0000);
    push_req(FUNC_TICK, 32'h8000_0032);
    drain();

    // Random runs on a different single segment, reset timing.
    write_reg(CFG_SINGLE_SEG, 3);
    wall_ms = $urandom;
    push_run(12, 1'b0, 1'b1);
    push_run(12, 1'b0, 1'b1);
    drain();

    // Widest segments and longest tail, no step interval: long, bright frames.
    // The pixel side is held off for a long stretch during this part.
    write_reg(CFG_LED_COUNT, MAX_LEDS);
    write_reg(CFG_TAIL_LENGTH, 255);
    write_reg(CFG_STEP_MS, 0);
    write_reg(CFG_PAUSE_MS, 0);
    write_reg(CFG_SINGLE_SEG, 11);
    hold_armed = 1'b1;
    push_run(12, 1'b0, 1'b1);
    drain();

    // Directed extremes: an over-range LED count is clamped, an out-of-range
    // segment stops the flow, and a zero tail gives only dark frames.
    write_reg(CFG_LED_COUNT, 1023);
    write_reg(CFG_TAIL_LENGTH, 0);
    write_reg(CFG_SINGLE_SEG, 15);
    push_req(FUNC_START, 32'd10);
    push_req(FUNC_TICK, 32'd20);
    drain();
    write_reg(CFG_SINGLE_SEG, 11);
    push_req(FUNC_START, 32'd30);
    push_req(FUNC_TICK, 32'd31);
    push_req(FUNC_TICK, 32'd32);
    drain();

    // No LEDs at all: every segment is empty in both modes.
    write_reg(CFG_LED_COUNT, 0);
    write_reg(CFG_ALL_SEGS, 1);
    push_req(FUNC_START, 32'd40);
    push_req(FUNC_TICK, 32'd41);
    drain();
    write_reg(CFG_ALL_SEGS, 0);
    push_req(FUNC_START, 32'd50);
    push_req(FUNC_TICK, 32'd51);
    drain();

    // All-segments mode over short segments, with no idling on either side,
    // long enough to walk through all twelve segments and stop at the end.
    write_reg(CFG_LED_COUNT, 30);
    write_reg(CFG_TAIL_LENGTH, 2);
    write_reg(CFG_STEP_MS, 1);
    write_reg(CFG_PAUSE_MS, 3);
    write_reg(CFG_SINGLE_SEG, 0);
    write_reg(CFG_ALL_SEGS, 1);
    steady = 1'b1;
    wall_ms = $urandom;
    push_run(70, 1'b1, 1'b0);
    drain();
    steady = 1'b0;

    // Fewer LEDs than segments: the last five are empty and skipped. Longest
    // step and pause times. Then single mode on one of the empty segments.
    write_reg(CFG_LED_COUNT, 7);
    write_reg(CFG_TAIL_LENGTH, 1);
    write_reg(CFG_STEP_MS, 65535);
    write_reg(CFG_PAUSE_MS, 65535);
    push_run(24, 1'b1, 1'b1);
    drain();
    write_reg(CFG_ALL_SEGS, 0);
    write_reg(CFG_SINGLE_SEG, 9);
    push_req(FUNC_START, wall_ms);
    push_req(FUNC_TICK, wall_ms + 32'd65535);
    drain();

    // Mid-sized strip with uneven segments, all mode with noise.
    write_reg(CFG_LED_COUNT, 100);
    write_reg(CFG_TAIL_LENGTH, 12);
    write_reg(CFG_STEP_MS, 20);
    write_reg(CFG_PAUSE_MS, 100);
    write_reg(CFG_ALL_SEGS, 1);
    push_run(14, 1'b1, 1'b1);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Hard limit on the run, far above the slowest correct one.
  initial begin : watchdog
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
